// ===== hdl/mtp_pkg.sv =====
package mtp_pkg;

  // Field widths
  localparam int DIM_W = 13;   // frame_width / frame_height
  localparam int ROW_W = 12;   // destination row within a plane
  localparam int OFF_W = 25;   // byte offset in the planar frame
  localparam int PIX_W = 8;    // sample byte
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  // Configuration reset values
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One classified request, handed from the front to the back
  typedef struct packed {
    logic             chroma;   // chroma byte (stride and base follow)
    logic             v_half;   // chroma byte of the V block
    logic             in_frame; // destination lies within the frame
    logic [ROW_W-1:0] row;      // destination row within its plane
    logic [DIM_W-1:0] col;      // destination column within its plane
    logic [PIX_W-1:0] pixel;
  } job_t;

endpackage

// ===== hdl/mtp_if.sv =====
// Tiled input byte channel
interface mtp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       plane_sel;
  logic                       frame_start;
  logic [mtp_pkg::PIX_W-1:0]  pixel_in;

  modport source(output valid, plane_sel, frame_start, pixel_in, input ready);
  modport sink(input valid, plane_sel, frame_start, pixel_in, output ready);
endinterface

// Placed byte channel
interface mtp_out_if;
  logic                       valid;
  logic                       ready;
  logic [mtp_pkg::OFF_W-1:0]  dest_offset;
  logic [mtp_pkg::PIX_W-1:0]  pixel_out;
  logic                       in_frame;

  modport source(output valid, dest_offset, pixel_out, in_frame, input ready);
  modport sink(input valid, dest_offset, pixel_out, in_frame, output ready);
endinterface

// ===== hdl/mtp_front.sv =====
module mtp_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  mtp_in_if.sink                    in_ch,
  input  logic [mtp_pkg::DIM_W-1:0] w_eff,
  input  logic [mtp_pkg::DIM_W-1:0] h_eff,
  input  logic                      q_full,
  output logic                      push,
  output mtp_pkg::job_t             push_job
);

  localparam int MbMax = (MAX_DIM + 15) / 16;
  localparam int MCW   = (MbMax > 1) ? $clog2(MbMax) : 1;
  localparam int N_W   = mtp_pkg::DIM_W - 3;

  // Position counters
  logic [MCW-1:0] l_mbcol_r, l_mbcol_nxt;
  logic [7:0]     l_mbrow_r, l_mbrow_nxt;
  logic [7:0]     l_pos_r,   l_pos_nxt;
  logic [MCW-1:0] c_mbcol_r, c_mbcol_nxt;
  logic [7:0]     c_mbrow_r, c_mbrow_nxt;
  logic [6:0]     c_pos_r,   c_pos_nxt;

  // Position of this request after an optional frame start
  logic [MCW-1:0]           l_mbcol, c_mbcol;
  logic [7:0]               l_mbrow, c_mbrow;
  logic [7:0]               l_p;
  logic [6:0]               c_p;
  logic [N_W-1:0]           mbs_row;
  logic [mtp_pkg::ROW_W-1:0] l_row, c_row;
  logic [mtp_pkg::DIM_W-1:0] l_col, c_col, cw, ch;
  logic                     l_in, c_in;
  logic                     l_wrap_col, c_wrap_col;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign l_mbcol = in_ch.frame_start ? '0 : l_mbcol_r;
  assign l_mbrow = in_ch.frame_start ? '0 : l_mbrow_r;
  assign l_p     = in_ch.frame_start ? '0 : l_pos_r;
  assign c_mbcol = in_ch.frame_start ? '0 : c_mbcol_r;
  assign c_mbrow = in_ch.frame_start ? '0 : c_mbrow_r;
  assign c_p     = in_ch.frame_start ? '0 : c_pos_r;

  // Macroblocks per row, at least one
  always_comb begin
    mbs_row = N_W'(({1'b0, w_eff} + 14'd15) >> 4);
    if (mbs_row == '0) begin
      mbs_row = N_W'(1);
    end
  end

  // Luma: four 8x8 blocks in raster order inside the macroblock
  assign l_row = {l_mbrow, l_p[7], l_p[5:3]};
  assign l_col = mtp_pkg::DIM_W'({l_mbcol, l_p[6], l_p[2:0]});
  assign l_in  = (mtp_pkg::DIM_W'(l_row) < h_eff) && (l_col < w_eff);

  // Chroma: U block then V block, both 8x8
  assign cw    = w_eff >> 1;
  assign ch    = h_eff >> 1;
  assign c_row = mtp_pkg::ROW_W'({c_mbrow, c_p[5:3]});
  assign c_col = mtp_pkg::DIM_W'({c_mbcol, c_p[2:0]});
  assign c_in  = (mtp_pkg::DIM_W'(c_row) < ch) && (c_col < cw);

  assign l_wrap_col = (N_W'(l_mbcol) + N_W'(1)) >= mbs_row;
  assign c_wrap_col = (N_W'(c_mbcol) + N_W'(1)) >= mbs_row;

  // Classify the request
  always_comb begin
    push_job.chroma   = in_ch.plane_sel;
    push_job.v_half   = c_p[6];
    push_job.in_frame = in_ch.plane_sel ? c_in : l_in;
    push_job.row      = in_ch.plane_sel ? c_row : l_row;
    push_job.col      = in_ch.plane_sel ? c_col : l_col;
    push_job.pixel    = in_ch.pixel_in;
  end

  // Advance the selected plane's counters
  always_comb begin
    l_mbcol_nxt = l_mbcol_r;
    l_mbrow_nxt = l_mbrow_r;
    l_pos_nxt   = l_pos_r;
    c_mbcol_nxt = c_mbcol_r;
    c_mbrow_nxt = c_mbrow_r;
    c_pos_nxt   = c_pos_r;
    if (push && !in_ch.plane_sel) begin
      l_pos_nxt   = l_p + 8'd1;
      l_mbcol_nxt = l_mbcol;
      l_mbrow_nxt = l_mbrow;
      if (l_p == 8'hFF) begin
        if (l_wrap_col) begin
          l_mbcol_nxt = '0;
          l_mbrow_nxt = l_mbrow + 8'd1;
        end else begin
          l_mbcol_nxt = l_mbcol + MCW'(1);
        end
      end
    end
    if (push && in_ch.plane_sel) begin
      c_pos_nxt   = c_p + 7'd1;
      c_mbcol_nxt = c_mbcol;
      c_mbrow_nxt = c_mbrow;
      if (c_p == 7'h7F) begin
        if (c_wrap_col) begin
          c_mbcol_nxt = '0;
          c_mbrow_nxt = c_mbrow + 8'd1;
        end else begin
          c_mbcol_nxt = c_mbcol + MCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_mbcol_r <= '0;
      l_mbrow_r <= '0;
      l_pos_r   <= '0;
      c_mbcol_r <= '0;
      c_mbrow_r <= '0;
      c_pos_r   <= '0;
    end else begin
      l_mbcol_r <= l_mbcol_nxt;
      l_mbrow_r <= l_mbrow_nxt;
      l_pos_r   <= l_pos_nxt;
      c_mbcol_r <= c_mbcol_nxt;
      c_mbrow_r <= c_mbrow_nxt;
      c_pos_r   <= c_pos_nxt;
    end
  end

endmodule

// ===== hdl/mtp_queue.sv =====
module mtp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mtp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output mtp_pkg::job_t pop_job
);

  localparam int PTR_W = (mtp_pkg::QUEUE_DEPTH > 1) ? $clog2(mtp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mtp_pkg::QUEUE_DEPTH + 1);

  mtp_pkg::job_t    slot_r [mtp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full    = (count_r == CNT_W'(mtp_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign pop_job = slot_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(mtp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(mtp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold the request payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hdl/mtp_back.sv =====
module mtp_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [mtp_pkg::DIM_W-1:0] w_eff,
  input  logic [mtp_pkg::DIM_W-1:0] h_eff,
  input  logic                      q_valid,
  input  mtp_pkg::job_t             pop_job,
  output logic                      pop,
  mtp_out_if.source                 out_ch
);

  localparam int YS_W = 2 * mtp_pkg::DIM_W;

  // Luma plane size, tracks the configuration
  logic [YS_W-1:0] ysize_r;

  // Multiply stage
  logic                      s1_v_r;
  logic [mtp_pkg::OFF_W-1:0] prod_r, prod_nxt;
  logic [mtp_pkg::OFF_W-1:0] addend_r, addend_nxt;
  logic                      s1_in_r;
  logic [mtp_pkg::PIX_W-1:0] s1_pix_r;

  // Output register
  logic                      out_v_r;
  logic [mtp_pkg::OFF_W-1:0] off_r;
  logic [mtp_pkg::PIX_W-1:0] pix_r;
  logic                      in_frame_r;

  logic                      s1_ready, s2_ready;
  logic [mtp_pkg::DIM_W-1:0] stride;
  logic [mtp_pkg::OFF_W-1:0] base_y, base_v;

  assign s2_ready = !out_v_r || out_ch.ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign pop      = q_valid && s1_ready;

  always_ff @(posedge clk) begin
    ysize_r <= w_eff * h_eff;
  end

  // Row times plane stride; column plus plane base alongside
  assign stride   = pop_job.chroma ? (w_eff >> 1) : w_eff;
  assign prod_nxt = pop_job.row * stride;
  assign base_y   = pop_job.chroma ? ysize_r[mtp_pkg::OFF_W-1:0] : '0;
  assign base_v   = (pop_job.chroma && pop_job.v_half) ?
                    mtp_pkg::OFF_W'(ysize_r[YS_W-1:2]) : '0;
  assign addend_nxt = base_y + base_v + mtp_pkg::OFF_W'(pop_job.col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= q_valid;
      end
      if (s2_ready) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prod_r   <= prod_nxt;
      addend_r <= addend_nxt;
      s1_in_r  <= pop_job.in_frame;
      s1_pix_r <= pop_job.pixel;
    end
    if (s2_ready && s1_v_r) begin
      off_r      <= s1_in_r ? (prod_r + addend_r) : '0;
      pix_r      <= s1_pix_r;
      in_frame_r <= s1_in_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.dest_offset = off_r;
  assign out_ch.pixel_out   = pix_r;
  assign out_ch.in_frame    = in_frame_r;

endmodule

// ===== hdl/macroblock_tile_to_planar_yuv.sv =====
// Converts a stream of macroblock-tiled luma and chroma bytes into byte offsets of a
// planar 4:2:0 frame (Y plane, then U at W*H, then V at W*H + W*H/4), passing each byte
// along with its offset and an in_frame flag; bytes whose row or column falls outside
// the frame get in_frame = 0 and offset 0. One byte is taken every clock while the queue
// is not full: the front classifies the byte from its plane's counters in the accepting
// cycle and pushes it into a two-entry queue, the back pops it into a registered
// row-times-stride multiply once that stage can take it, and the final add lands in the
// output register. Both sides stall independently; once a long output stall has filled
// the queue, input is taken again from the edge after the first result leaves.
// Dimensions above MAX_DIM are clamped.
// Write frame_width and frame_height only while no request is in flight.
module macroblock_tile_to_planar_yuv #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mtp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtp_pkg::DIM_W-1:0]     cfg_wdata,
  mtp_in_if.sink                        in_ch,
  mtp_out_if.source                     out_ch
);

  logic [mtp_pkg::DIM_W-1:0] width_r, height_r;
  logic [mtp_pkg::DIM_W-1:0] w_eff, h_eff;

  logic          push, q_full, pop, q_valid;
  mtp_pkg::job_t push_job, pop_job;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mtp_pkg::FRAME_WIDTH_RST;
      height_r <= mtp_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtp_pkg::CFG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        mtp_pkg::CFG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp dimensions to the supported maximum
  assign w_eff = (32'(width_r) > MAX_DIM)  ? mtp_pkg::DIM_W'(MAX_DIM) : width_r;
  assign h_eff = (32'(height_r) > MAX_DIM) ? mtp_pkg::DIM_W'(MAX_DIM) : height_r;

  mtp_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  mtp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_job  (pop_job)
  );

  mtp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .q_valid (q_valid),
    .pop_job (pop_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
